// ===== hdl/pixel_pack_block_writer_macros.svh =====
// Assertion macros shared by the pixel packing block writer.
`ifndef PIXEL_PACK_BLOCK_WRITER_MACROS_SVH
`define PIXEL_PACK_BLOCK_WRITER_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define PPBW_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pixel_pack_block_writer: check failed");
// Two conditions that must never be true together.
`define PPBW_ASSERT_EXCL(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !((a) && (b))) \
		else $error("pixel_pack_block_writer: exclusive conditions met");
`else
`define PPBW_ASSERT(label, prop)
`define PPBW_ASSERT_EXCL(label, a, b)
`endif
`endif

// ===== hdl/ppbw_pkg.sv =====
// Package of shared constants and types for the pixel packing block writer.
package ppbw_pkg;

	localparam int BLOCK_WORDS = 16;
	localparam int BLOCK_COUNT = 2;
	localparam int STORE_DEPTH = BLOCK_WORDS * BLOCK_COUNT;
	localparam int WORD_W      = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int BLK_W       = $clog2(BLOCK_COUNT);
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int CREDIT_W    = $clog2(BLOCK_COUNT + 1);
	localparam int BLOCK_BYTES = 4 * BLOCK_WORDS;

	localparam logic [31:0] FRAME_BASE_RST  = 32'h4000_5000;
	localparam logic [23:0] FRAME_BYTES_RST = 24'h04_B000;
	localparam logic [31:0] RAM_END_RST     = 32'h4100_0000;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAM_END     = 2'd2;

	typedef struct packed {
		logic                en;
		logic [STORE_AW-1:0] addr;
		logic [31:0]         data;
	} store_wr_t;

	typedef struct packed {
		logic             valid;
		logic [BLK_W-1:0] blk;
	} blk_push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] data;
		logic        last;
	} out_word_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WRAP
	} back_state_t;

endpackage

// ===== hdl/ppbw_front.sv =====
// Front end: packs pixels into words, writes them to the store and posts full blocks.
module ppbw_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     px_valid,
	output logic                     px_ready,
	input  logic [7:0]               pixel,
	input  logic                     blk_done,
	output ppbw_pkg::store_wr_t      store_wr,
	output ppbw_pkg::blk_push_t      push
);

	logic [1:0]                     lane_q;
	logic [ppbw_pkg::WORD_W-1:0]    word_q;
	logic [ppbw_pkg::BLK_W-1:0]     fill_blk_q;
	logic [ppbw_pkg::CREDIT_W-1:0]  credits_q;
	logic [7:0]                     byte0_q;
	logic [7:0]                     byte1_q;
	logic [7:0]                     byte2_q;
	logic                           take;
	logic                           word_done;
	logic                           block_end;

	// A free block exists while credits remain; the block being filled holds one.
	assign px_ready  = (credits_q != '0);
	assign take      = px_valid && px_ready;
	assign word_done = take && (lane_q == 2'd3);
	assign block_end = word_done && (word_q == ppbw_pkg::WORD_W'(ppbw_pkg::BLOCK_WORDS - 1));

	assign store_wr.en   = word_done;
	assign store_wr.addr = ppbw_pkg::STORE_AW'(fill_blk_q) *
		ppbw_pkg::STORE_AW'(ppbw_pkg::BLOCK_WORDS) + ppbw_pkg::STORE_AW'(word_q);
	assign store_wr.data = {pixel, byte2_q, byte1_q, byte0_q};

	assign push.valid = block_end;
	assign push.blk   = fill_blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q     <= '0;
			word_q     <= '0;
			fill_blk_q <= '0;
			credits_q  <= ppbw_pkg::CREDIT_W'(ppbw_pkg::BLOCK_COUNT);
		end else begin
			if (take) begin
				lane_q <= lane_q + 2'd1;
			end
			if (word_done) begin
				if (block_end) begin
					word_q <= '0;
				end else begin
					word_q <= word_q + 1'b1;
				end
			end
			if (block_end) begin
				if (fill_blk_q == ppbw_pkg::BLK_W'(ppbw_pkg::BLOCK_COUNT - 1)) begin
					fill_blk_q <= '0;
				end else begin
					fill_blk_q <= fill_blk_q + 1'b1;
				end
			end
			if (block_end && !blk_done) begin
				credits_q <= credits_q - 1'b1;
			end else if (!block_end && blk_done) begin
				credits_q <= credits_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			case (lane_q)
				2'd0: byte0_q <= pixel;
				2'd1: byte1_q <= pixel;
				2'd2: byte2_q <= pixel;
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/ppbw_queue.sv =====
// Short queue of completed block numbers between the front and back ends.
module ppbw_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppbw_pkg::blk_push_t          push,
	input  logic                         pop,
	output logic [ppbw_pkg::BLK_W-1:0]   head_blk,
	output ppbw_pkg::q_stat_t            stat
);

	logic [ppbw_pkg::BLK_W-1:0]    entry_q [ppbw_pkg::BLOCK_COUNT];
	logic [ppbw_pkg::BLK_W-1:0]    wr_ptr_q;
	logic [ppbw_pkg::BLK_W-1:0]    rd_ptr_q;
	logic [ppbw_pkg::CREDIT_W-1:0] count_q;

	assign head_blk   = entry_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == ppbw_pkg::CREDIT_W'(ppbw_pkg::BLOCK_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				if (wr_ptr_q == ppbw_pkg::BLK_W'(ppbw_pkg::BLOCK_COUNT - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == ppbw_pkg::BLK_W'(ppbw_pkg::BLOCK_COUNT - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.blk;
		end
	end

endmodule

// ===== hdl/ppbw_back.sv =====
// Back end: word store, block drain sequencer, address wrap and output buffer.
module ppbw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppbw_pkg::store_wr_t         store_wr,
	input  ppbw_pkg::q_stat_t           q_stat,
	input  logic [ppbw_pkg::BLK_W-1:0]  head_blk,
	output logic                        pop,
	output logic                        blk_done,
	input  logic [31:0]                 frame_base,
	input  logic [23:0]                 frame_bytes,
	input  logic [31:0]                 ram_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ppbw_pkg::out_word_t         out_word
);

	logic [31:0]                   store_q [ppbw_pkg::STORE_DEPTH];

	ppbw_pkg::back_state_t         state_q;
	ppbw_pkg::back_state_t         state_d;
	logic [ppbw_pkg::BLK_W-1:0]    blk_q;
	logic [ppbw_pkg::WORD_W-1:0]   k_q;
	logic [31:0]                   word_addr_q;
	logic [31:0]                   next_addr_q;
	logic [32:0]                   cand_q;

	logic                          s1_valid_s1;
	logic [31:0]                   s1_addr_s1;
	logic [31:0]                   s1_data_s1;
	logic                          s1_last_s1;

	ppbw_pkg::out_word_t           buf_q [2];
	logic                          buf_wr_q;
	logic                          buf_rd_q;
	logic [1:0]                    buf_cnt_q;

	logic                          issue;
	logic                          last_word;
	logic                          out_pop;
	logic [2:0]                    occ;
	logic [ppbw_pkg::STORE_AW-1:0] rd_addr;
	logic                          past_end;
	logic                          frame_full;
	logic [33:0]                   cand_end;
	logic [31:0]                   frame_off;

	assign out_valid = (buf_cnt_q != 2'd0);
	assign out_word  = buf_q[buf_rd_q];
	assign out_pop   = out_valid && out_ready;

	// Room is reserved for every word in flight so the read never has to stall.
	assign occ = {1'b0, buf_cnt_q} + {2'b0, s1_valid_s1} - {2'b0, out_pop};

	assign last_word = (k_q == ppbw_pkg::WORD_W'(ppbw_pkg::BLOCK_WORDS - 1));
	assign rd_addr   = ppbw_pkg::STORE_AW'(blk_q) *
		ppbw_pkg::STORE_AW'(ppbw_pkg::BLOCK_WORDS) + ppbw_pkg::STORE_AW'(k_q);

	assign cand_end   = {1'b0, cand_q} + 34'(ppbw_pkg::BLOCK_BYTES);
	assign past_end   = cand_end > {2'b00, ram_end};
	assign frame_off  = cand_q[31:0] - frame_base;
	assign frame_full = frame_off >= {8'h00, frame_bytes};

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		issue    = 1'b0;
		blk_done = 1'b0;
		case (state_q)
			ppbw_pkg::BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = ppbw_pkg::BK_READ;
				end
			end
			ppbw_pkg::BK_READ: begin
				if (occ <= 3'd1) begin
					issue = 1'b1;
					if (last_word) begin
						blk_done = 1'b1;
						state_d  = ppbw_pkg::BK_WRAP;
					end
				end
			end
			ppbw_pkg::BK_WRAP: begin
				state_d = ppbw_pkg::BK_IDLE;
			end
			default: begin
				state_d = ppbw_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppbw_pkg::BK_IDLE;
			next_addr_q <= ppbw_pkg::FRAME_BASE_RST;
			s1_valid_s1 <= 1'b0;
			buf_wr_q    <= 1'b0;
			buf_rd_q    <= 1'b0;
			buf_cnt_q   <= 2'd0;
		end else begin
			state_q     <= state_d;
			s1_valid_s1 <= issue;
			if (state_q == ppbw_pkg::BK_WRAP) begin
				if (past_end || frame_full) begin
					next_addr_q <= frame_base;
				end else begin
					next_addr_q <= cand_q[31:0];
				end
			end
			if (s1_valid_s1) begin
				buf_wr_q <= ~buf_wr_q;
			end
			if (out_pop) begin
				buf_rd_q <= ~buf_rd_q;
			end
			if (s1_valid_s1 && !out_pop) begin
				buf_cnt_q <= buf_cnt_q + 2'd1;
			end else if (!s1_valid_s1 && out_pop) begin
				buf_cnt_q <= buf_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			blk_q       <= head_blk;
			k_q         <= '0;
			word_addr_q <= next_addr_q;
		end
		if (issue) begin
			k_q         <= k_q + 1'b1;
			word_addr_q <= word_addr_q + 32'd4;
			s1_addr_s1  <= word_addr_q;
			s1_last_s1  <= last_word;
			s1_data_s1  <= store_q[rd_addr];
		end
		if (issue && last_word) begin
			cand_q <= {1'b0, next_addr_q} + 33'(ppbw_pkg::BLOCK_BYTES);
		end
		if (s1_valid_s1) begin
			buf_q[buf_wr_q] <= '{addr: s1_addr_s1, data: s1_data_s1, last: s1_last_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			store_q[store_wr.addr] <= store_wr.data;
		end
	end

endmodule

// ===== hdl/pixel_pack_block_writer.sv =====
// Top level of the pixel packing block writer.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  pixel
//  m_axis    out        m_axis_tvalid / m_axis_tready  write_address, write_data, tlast
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// The input takes one pixel word per cycle while a free block remains in the ring store.
// A full block drains with one store read per output word while the output buffer has
// room, then a wrap state decides the next address and the idle state pops the next block.
// When both blocks wait to drain, s_axis_tready falls until the oldest has been read.
// Reset clears all control state and loads the register reset values; no clearing pass.
// A stalled output holds up the drain only; the front keeps filling its block meanwhile.
`include "pixel_pack_block_writer_macros.svh"
module pixel_pack_block_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] write_address, [63:32] write_data
	output logic        m_axis_tlast,   // last word of a block
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// Configuration registers, to be written only while the block is idle; the block does not enforce this.
	logic [31:0] frame_base_q;
	logic [23:0] frame_bytes_q;
	logic [31:0] ram_end_q;

	ppbw_pkg::store_wr_t         store_wr;
	ppbw_pkg::blk_push_t         push;
	ppbw_pkg::q_stat_t           q_stat;
	ppbw_pkg::out_word_t         out_word;
	logic [ppbw_pkg::BLK_W-1:0]  head_blk;
	logic                        pop;
	logic                        blk_done;

	// The register port never stalls. An unknown index is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= ppbw_pkg::FRAME_BASE_RST;
			frame_bytes_q <= ppbw_pkg::FRAME_BYTES_RST;
			ram_end_q     <= ppbw_pkg::RAM_END_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppbw_pkg::REG_FRAME_BASE:  frame_base_q  <= cfg_data;
				ppbw_pkg::REG_FRAME_BYTES: frame_bytes_q <= cfg_data[23:0];
				ppbw_pkg::REG_RAM_END:     ram_end_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: assembles each word from four pixels, lowest byte first.
	ppbw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.px_valid (s_axis_tvalid),
		.px_ready (s_axis_tready),
		.pixel    (s_axis_tdata),
		.blk_done (blk_done),
		.store_wr (store_wr),
		.push     (push)
	);

	// Completed block numbers wait here until the back end is free.
	ppbw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.head_blk (head_blk),
		.stat     (q_stat)
	);

	// Back end: reads a block out of the store and emits it at the running address.
	ppbw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.store_wr    (store_wr),
		.q_stat      (q_stat),
		.head_blk    (head_blk),
		.pop         (pop),
		.blk_done    (blk_done),
		.frame_base  (frame_base_q),
		.frame_bytes (frame_bytes_q),
		.ram_end     (ram_end_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_word    (out_word)
	);

	assign m_axis_tdata = {out_word.data, out_word.addr};
	assign m_axis_tlast = out_word.last;

	// A full queue means every block is spoken for, so the input must be closed.
	`PPBW_ASSERT_EXCL(a_full_closes_input, q_stat.full, s_axis_tready)
	// A block can only be posted when the queue has room for it.
	`PPBW_ASSERT_EXCL(a_no_push_when_full, push.valid, q_stat.full)
	// The back end only takes a block that is actually waiting.
	`PPBW_ASSERT(a_pop_needs_entry, pop |-> !q_stat.empty)
	// Output words stay word aligned.
	`PPBW_ASSERT(a_word_aligned, m_axis_tvalid |-> (m_axis_tdata[1:0] == 2'b00 ||
		$past(blk_done, 1) || !$stable(frame_base_q)))

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the pixel packing block writer.
`timescale 1ns / 100ps

// Tracks the packer's state and configuration, and holds the memory writes still owed.
class block_write_predictor;
	logic [31:0]         frame_origin;
	logic [23:0]         frame_span;
	logic [31:0]         ram_limit;
	logic [31:0]         ring [ppbw_pkg::STORE_DEPTH];
	logic [1:0]          lane;
	int unsigned         word_pos;
	int unsigned         fill_blk;
	logic [31:0]         dest_addr;
	ppbw_pkg::out_word_t pending_writes [$];
	int unsigned         errors;

	function new();
		frame_origin = ppbw_pkg::FRAME_BASE_RST;
		frame_span   = ppbw_pkg::FRAME_BYTES_RST;
		ram_limit    = ppbw_pkg::RAM_END_RST;
		lane         = 2'd0;
		word_pos     = 0;
		fill_blk     = 0;
		dest_addr    = ppbw_pkg::FRAME_BASE_RST;
		errors       = 0;
		foreach (ring[i])
			ring[i] = '0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] val);
		case (idx)
			ppbw_pkg::REG_FRAME_BASE:  frame_origin = val;
			ppbw_pkg::REG_FRAME_BYTES: frame_span   = val[23:0];
			ppbw_pkg::REG_RAM_END:     ram_limit    = val;
			default: ;
		endcase
	endfunction

	// Places one pixel; when a block completes, queues its writes and moves the address on.
	function void take_pixel(logic [7:0] px);
		ppbw_pkg::out_word_t w;
		logic [33:0]         ahead;
		ring[fill_blk * ppbw_pkg::BLOCK_WORDS + word_pos][8 * lane +: 8] = px;
		lane = lane + 2'd1;
		if (lane != 2'd0)
			return;
		word_pos++;
		if (word_pos < ppbw_pkg::BLOCK_WORDS)
			return;
		word_pos = 0;
		for (int k = 0; k < ppbw_pkg::BLOCK_WORDS; k++) begin
			w.addr = dest_addr + 32'(4 * k);
			w.data = ring[fill_blk * ppbw_pkg::BLOCK_WORDS + k];
			w.last = (k == ppbw_pkg::BLOCK_WORDS - 1);
			pending_writes.push_back(w);
		end
		ahead = {2'b00, dest_addr} + 34'(ppbw_pkg::BLOCK_BYTES);
		if (ahead + 34'(ppbw_pkg::BLOCK_BYTES) > {2'b00, ram_limit} ||
				(ahead[31:0] - frame_origin) >= {8'h00, frame_span})
			dest_addr = frame_origin;
		else
			dest_addr = ahead[31:0];
		fill_blk = (fill_blk + 1) % ppbw_pkg::BLOCK_COUNT;
	endfunction

	task report(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	task check_write(input logic [31:0] addr, input logic [31:0] data, input logic last);
		ppbw_pkg::out_word_t w;
		if (pending_writes.size() == 0) begin
			report($sformatf("unexpected write addr %h data %h last %b", addr, data, last));
			return;
		end
		w = pending_writes.pop_front();
		if (addr !== w.addr)
			report($sformatf("address %h, expected %h", addr, w.addr));
		if (data !== w.data)
			report($sformatf("data %h at %h, expected %h", data, w.addr, w.data));
		if (last !== w.last)
			report($sformatf("tlast %b at %h, expected %b", last, w.addr, w.last));
	endtask
endclass

module tb_top;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;
	// Cycles the receiver refuses words during the back-pressure phase.
	localparam int HOLD_CYCLES = 300;
	// Margin after the last owed write; the wrap decision is made before that write leaves.
	localparam int SETTLE_CYCLES = 2 * ppbw_pkg::BLOCK_WORDS;
	localparam int CYCLE_LIMIT = 100000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] pixel
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [31:0] write_address, [63:32] write_data
	logic        m_axis_tlast;   // last word of a block
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	block_write_predictor book;
	bit          drain_hold_req;
	int unsigned cycle_count;

	pixel_pack_block_writer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run rather than letting it spin forever.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one pixel word after the given gap and returns at the edge where it is taken.
	// Valid is left high afterwards, so back-to-back words never lower and raise it in one step.
	task automatic send_pixel(input logic [7:0] px, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		book.take_pixel(px);
	endtask

	// Register writes follow the same pattern; the caller lowers cfg_valid after the batch.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		book.write_reg(idx, val);
	endtask

	// Waits until every owed write has arrived and the address wrap has been decided.
	task automatic settle();
		while (book.pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One phase: a full set of register writes while idle, then a run of random pixels.
	// A partial block may be left over, so the next phase's writes land mid-frame.
	task automatic run_phase(input logic [31:0] base, input logic [31:0] span,
			input logic [31:0] limit, input int count, input int gap_max, input bit squeeze);
		write_reg(ppbw_pkg::REG_FRAME_BASE, base);
		write_reg(ppbw_pkg::REG_FRAME_BYTES, span);
		write_reg(ppbw_pkg::REG_RAM_END, limit);
		write_reg(REG_SPARE, $urandom);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (squeeze)
			drain_hold_req = 1'b1;
		repeat (count)
			send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, gap_max));
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		settle();
	endtask

	// Receiver: draws a wait before each word, with calm stretches of no waiting at all,
	// and one long refusal when the back-pressure phase asks for it.
	initial begin
		int unsigned pause_len;
		int unsigned taken;
		bit          calm;
		taken = 0;
		calm  = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken % 24 == 0)
				calm = $urandom_range(0, 1);
			pause_len = calm ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (drain_hold_req) begin
				drain_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (pause_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (pause_len) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			book.check_write(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
			taken++;
		end
	end

	initial begin
		logic [7:0] edge_pixels [24];
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = 8'h00;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = ppbw_pkg::REG_FRAME_BASE;
		cfg_data       = 32'h0;
		drain_hold_req = 1'b0;
		cycle_count    = 0;
		book           = new();
		edge_pixels    = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h04, 8'h08,
				8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7,
				8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h0F, 8'hF0, 8'h00, 8'hFF};
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset register values: extreme and walking-bit pixels, then random ones up to
		// the first full block at the reset frame base.
		foreach (edge_pixels[i])
			send_pixel(edge_pixels[i], $urandom_range(0, 15));
		repeat (ppbw_pkg::BLOCK_BYTES - 24)
			send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 15));
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		settle();

		// Highest base: the running address is past the frame count and returns to the top.
		run_phase(32'hFFFF_FFFC, 32'h00FF_FFFF, 32'hFFFF_FFFF, 64, 15, 1'b0);
		// Zero frame bytes, with junk in the unused top byte: the block at the top rolls the
		// word addresses over zero, the next step overflows and the address goes back to base.
		run_phase(32'h0000_0000, 32'hAB00_0000, 32'hFFFF_FFFF, 64, 0, 1'b0);
		// RAM end exactly two blocks above base, under a long receiver stall so the ring
		// fills and the input stops: the block at base still fits below the RAM end.
		run_phase(32'h0000_0100, 32'h00FF_FFFF, 32'h0000_0180, 150, 0, 1'b1);
		// A four-byte frame and a RAM end of zero.
		run_phase(32'h0000_2000, 32'h0000_0004, 32'h0000_0000, 80, 15, 1'b0);

		if (book.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ppbw_pkg.sv
hdl/ppbw_front.sv
hdl/ppbw_queue.sv
hdl/ppbw_back.sv
hdl/pixel_pack_block_writer.sv
verif/tb_top.sv
